FILE: rtl/core/sstt_pkg.sv
`timescale 1ns / 1ps

package sstt_pkg;

	localparam int TABLE_DEPTH_DEF = 64;
	localparam int COORD_W = 16;
	localparam int VALUE_W = 32;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [COORD_W-1:0] ROW_COUNT_RST = 16'hFFFF;
	localparam logic [COORD_W-1:0] COLUMN_COUNT_RST = 16'hFFFF;

	// configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_ROW_COUNT = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_COLUMN_COUNT = 2'd1;

	// operation codes
	localparam logic MODE_READ = 1'b0;
	localparam logic MODE_MODIFY = 1'b1;

	typedef enum logic [1:0] {
		STAT_OK = 2'd0,
		STAT_RANGE = 2'd1,
		STAT_FULL = 2'd2
	} status_t;

	typedef enum logic {
		IDLE,
		UPDATE
	} state_t;

	typedef struct packed {
		logic mode;
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
		logic signed [VALUE_W-1:0] new_value;
	} request_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] old_value;
		logic [1:0] status;
	} result_t;

	typedef struct packed {
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
		logic signed [VALUE_W-1:0] value;
	} entry_t;

	// broadcast to every cell of the chain
	typedef struct packed {
		logic cmp_en;
		logic upd_en;
		logic ins_en;
	} cell_ctrl_t;

endpackage

FILE: rtl/core/sstt_cell.sv
`timescale 1ns / 1ps

module sstt_cell import sstt_pkg::*; (
	input logic clk,
	input cell_ctrl_t ctrl,
	input logic [COORD_W-1:0] cmp_row,
	input logic [COORD_W-1:0] cmp_col,
	input logic occupied,
	input entry_t ins_entry,
	input entry_t prev_entry,
	input logic prev_before,
	output entry_t entry,
	output logic ahead,
	output logic match,
	output logic signed [VALUE_W-1:0] hit_value
);

	entry_t entry_q;
	logic match_q;
	logic before_q;

	always_ff @(posedge clk) begin
		if (ctrl.cmp_en) begin
			match_q <= occupied && (entry_q.row == cmp_row) && (entry_q.col == cmp_col);
			before_q <= occupied && ((entry_q.row < cmp_row) ||
				((entry_q.row == cmp_row) && (entry_q.col < cmp_col)));
		end
		if (ctrl.ins_en) begin
			// cells at or past the insert point move up by one
			if (!before_q) begin
				entry_q <= prev_before ? ins_entry : prev_entry;
			end
		end else if (ctrl.upd_en && match_q) begin
			entry_q.value <= ins_entry.value;
		end
	end

	assign entry = entry_q;
	assign ahead = before_q;
	assign match = match_q;
	assign hit_value = match_q ? entry_q.value : '0;

endmodule

FILE: rtl/core/sorted_sparse_triple_table_unit.sv
`timescale 1ns / 1ps
// timing: the done strobe is registered from the update state entered on accept
// flow: busy holds off a new transaction until the last one has left the update state;
// each passes the cell compare step, then the update step that shifts or overwrites the chain
// reset: entry count cleared, row and column counts set to 65535, table contents
// left as they are (no clearing pass); the receiver cannot stall results

module sorted_sparse_triple_table_unit import sstt_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input request_t request,
	output logic done,
	output result_t result,
	input logic cfg_we,
	input logic [CFG_INDEX_W-1:0] cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	// control state
	state_t state_q, state_d;
	logic [CNT_W-1:0] count_q;
	logic [COORD_W-1:0] row_count_q;
	logic [COORD_W-1:0] column_count_q;
	logic done_q;

	// transaction held across the update cycle
	entry_t key_q;
	logic mode_q;
	logic range_q;
	result_t result_q;

	// chain wiring
	cell_ctrl_t ctrl;
	entry_t entry_vec [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] before_vec;
	logic [TABLE_DEPTH-1:0] match_vec;
	logic [TABLE_DEPTH-1:0] occupied_vec;
	logic signed [VALUE_W-1:0] hit_vec [TABLE_DEPTH];

	logic accept;
	logic hit;
	logic full;
	logic signed [VALUE_W-1:0] hit_value;
	result_t result_d;
	logic count_inc;

	assign accept = start && (state_q == IDLE);
	assign busy = (state_q != IDLE);
	assign full = (count_q == CNT_W'(TABLE_DEPTH));

	// the row of cells; each hands its entry and its sort flag to the next one up
	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		assign occupied_vec[i] = (CNT_W'(i) < count_q);
		if (i == 0) begin : g_head
			sstt_cell u_cell (
				.clk(clk),
				.ctrl(ctrl),
				.cmp_row(request.row),
				.cmp_col(request.col),
				.occupied(occupied_vec[i]),
				.ins_entry(key_q),
				.prev_entry(key_q),
				.prev_before(1'b1),
				.entry(entry_vec[i]),
				.ahead(before_vec[i]),
				.match(match_vec[i]),
				.hit_value(hit_vec[i])
			);
		end else begin : g_body
			sstt_cell u_cell (
				.clk(clk),
				.ctrl(ctrl),
				.cmp_row(request.row),
				.cmp_col(request.col),
				.occupied(occupied_vec[i]),
				.ins_entry(key_q),
				.prev_entry(entry_vec[i-1]),
				.prev_before(before_vec[i-1]),
				.entry(entry_vec[i]),
				.ahead(before_vec[i]),
				.match(match_vec[i]),
				.hit_value(hit_vec[i])
			);
		end
	end

	// at most one cell matches, so an or of the masked values picks it out
	always_comb begin
		hit_value = '0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			hit_value = hit_value | hit_vec[i];
		end
	end

	assign hit = |match_vec;

	// next state, chain control and result
	always_comb begin
		state_d = state_q;
		ctrl = '0;
		ctrl.cmp_en = accept;
		result_d = result_q;
		count_inc = 1'b0;
		unique case (state_q)
			IDLE: begin
				if (accept) begin
					state_d = UPDATE;
				end
			end
			UPDATE: begin
				state_d = IDLE;
				result_d.old_value = '0;
				result_d.status = STAT_OK;
				if (range_q) begin
					result_d.status = STAT_RANGE;
				end else if (hit) begin
					// existing cell: report it, overwrite on modify
					result_d.old_value = hit_value;
					ctrl.upd_en = (mode_q == MODE_MODIFY);
				end else if (mode_q == MODE_MODIFY) begin
					if (full) begin
						result_d.status = STAT_FULL;
					end else begin
						// new cell goes in at its sorted place
						ctrl.ins_en = 1'b1;
						count_inc = 1'b1;
					end
				end
			end
			default: begin
				state_d = IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			count_q <= '0;
			row_count_q <= ROW_COUNT_RST;
			column_count_q <= COLUMN_COUNT_RST;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q <= (state_q == UPDATE);
			if (count_inc) begin
				count_q <= count_q + CNT_W'(1);
			end
			// writes beyond the register list fall through
			if (cfg_we) begin
				case (cfg_index)
					CFG_ROW_COUNT: row_count_q <= cfg_data;
					CFG_COLUMN_COUNT: column_count_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// transaction capture and result register
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q.row <= request.row;
			key_q.col <= request.col;
			key_q.value <= request.new_value;
			mode_q <= request.mode;
			range_q <= (request.row >= row_count_q) || (request.col >= column_count_q);
		end
		result_q <= result_d;
	end

	assign done = done_q;
	assign result = result_q;

`ifndef NO_ASSERTIONS
	// a result strobe always follows an update cycle
	a_done_after_update: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == UPDATE))
		else $error("result strobe without an update cycle");

	// sorted table of distinct cells: never more than one match
	a_single_match: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == UPDATE) |-> $onehot0(match_vec))
		else $error("more than one cell matched");

	// fill count stays within the chain
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TABLE_DEPTH))
		else $error("entry count beyond table depth");

	// an insert only happens with room left and no matching cell
	a_insert_legal: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.ins_en |-> (!full && !hit && !range_q))
		else $error("insert into full table or over an existing cell");
`endif

endmodule
